>>> rtl/core/gcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcl_pkg - shared types and constants for the 3x3 grey closing core
// Pixel and register widths, register indexes, the classification record
// passed from front to back, queue status and small min/max helpers.
// ----------------------------------------------------------------------------
package gcl_pkg;

    localparam int PIX_W      = 8;
    localparam int FW_W       = 11;
    localparam int FH_W       = 12;
    localparam int CFG_W      = 12;
    localparam int CFG_ADDR_W = 1;
    localparam int ROW_W      = 12;

    localparam int FW_RESET = 640;
    localparam int FH_RESET = 480;
    localparam int MIN_DIM  = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // per-pixel classification, decided from the raster position
    typedef struct packed {
        logic emit;       // a result is due for this pixel
        logic interior;   // result position is far enough from every border
        logic frame_end;  // last emitted result of the frame
    } t_cls;

    localparam int CLS_W = $bits(t_cls);

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_sts;

    function automatic logic [PIX_W-1:0] max3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic logic [PIX_W-1:0] min3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

endpackage

>>> rtl/core/gcl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcl_queue - short request queue between front and back
// Register-based FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module gcl_queue #(
    parameter int DW    = 21,
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [DW-1:0]       i_data,
    input  logic                i_pop,
    output logic [DW-1:0]       o_data,
    output gcl_pkg::t_q_sts     o_sts
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;
    logic          w_do_push;
    logic          w_do_pop;

    assign w_do_pop  = i_pop && (r_cnt != '0);
    assign w_do_push = i_push && (r_cnt != (AW+1)'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(w_do_push) - (AW+1)'(w_do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data      = r_mem[r_rd];
    assign o_sts.empty = (r_cnt == '0);
    assign o_sts.full  = (r_cnt == (AW+1)'(DEPTH));

endmodule

>>> rtl/core/gcl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcl_front - pixel intake, raster counters and classification
// Holds the frame size registers, tracks the raster position of each
// accepted pixel and tags it with what the back end must produce for it.
// ----------------------------------------------------------------------------
module gcl_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gcl_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [gcl_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [gcl_pkg::PIX_W-1:0]         i_pixel,
    input  logic                              i_q_full,
    output logic                              o_push,
    output logic [gcl_pkg::PIX_W-1:0]         o_pixel,
    output logic [$clog2(MAX_WIDTH)-1:0]      o_col,
    output gcl_pkg::t_cls                     o_cls
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int EW    = CW + 1;
    localparam int WW    = (EW > gcl_pkg::FW_W) ? EW : gcl_pkg::FW_W;
    localparam int W_RST = (MAX_WIDTH < gcl_pkg::FW_RESET) ? MAX_WIDTH : gcl_pkg::FW_RESET;

    logic [CW-1:0]               r_col;
    logic [gcl_pkg::ROW_W-1:0]   r_row;
    logic [CW-1:0]               r_col_last;
    logic [gcl_pkg::ROW_W-1:0]   r_row_last;
    logic [CW-1:0]               n_col_last;
    logic [gcl_pkg::ROW_W-1:0]   n_row_last;
    logic [WW-1:0]               w_fw;
    logic [WW-1:0]               w_fw_clamp;
    logic [gcl_pkg::FH_W-1:0]    w_fh;
    logic [gcl_pkg::FH_W-1:0]    w_fh_clamp;
    logic                        w_col_end;
    logic                        w_row_end;

    // effective frame size, stored as last column / last row
    always_comb begin
        w_fw = WW'(i_cfg_wdata[gcl_pkg::FW_W-1:0]);
        if (w_fw < WW'(gcl_pkg::MIN_DIM)) begin
            w_fw_clamp = WW'(gcl_pkg::MIN_DIM);
        end else if (w_fw > WW'(MAX_WIDTH)) begin
            w_fw_clamp = WW'(MAX_WIDTH);
        end else begin
            w_fw_clamp = w_fw;
        end
        n_col_last = CW'(w_fw_clamp - WW'(1));

        w_fh       = i_cfg_wdata[gcl_pkg::FH_W-1:0];
        w_fh_clamp = (w_fh < gcl_pkg::FH_W'(gcl_pkg::MIN_DIM)) ?
                     gcl_pkg::FH_W'(gcl_pkg::MIN_DIM) : w_fh;
        n_row_last = gcl_pkg::ROW_W'(w_fh_clamp - gcl_pkg::FH_W'(1));
    end

    assign o_ready   = !i_q_full;
    assign o_push    = i_valid && !i_q_full;
    assign w_col_end = (r_col == r_col_last);
    assign w_row_end = (r_row == r_row_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_col_last <= CW'(W_RST - 1);
            r_row_last <= gcl_pkg::ROW_W'(gcl_pkg::FH_RESET - 1);
        end else if (i_cfg_we) begin
            // any register write restarts the frame
            r_col <= '0;
            r_row <= '0;
            unique case (i_cfg_addr)
                gcl_pkg::CFG_FRAME_WIDTH:  r_col_last <= n_col_last;
                gcl_pkg::CFG_FRAME_HEIGHT: r_row_last <= n_row_last;
            endcase
        end else if (o_push) begin
            if (w_col_end) begin
                r_col <= '0;
                r_row <= w_row_end ? '0 : r_row + gcl_pkg::ROW_W'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Result for pixel (row, col) belongs to the position 2W+2 pixels back.
    // It lies inside the two-pixel border exactly when row >= 4 and col >= 4.
    assign o_pixel           = i_pixel;
    assign o_col             = r_col;
    assign o_cls.emit        = (r_row >= gcl_pkg::ROW_W'(3)) ||
                               ((r_row == gcl_pkg::ROW_W'(2)) && ({1'b0, r_col} >= EW'(2)));
    assign o_cls.interior    = (r_row >= gcl_pkg::ROW_W'(4)) && ({1'b0, r_col} >= EW'(4));
    assign o_cls.frame_end   = w_col_end && w_row_end;

endmodule

>>> rtl/core/gcl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcl_back - dilation and erosion pipeline
// Two line memories (input rows, dilated rows) feed 3x3 max then 3x3 min
// windows; every stage moves together when the output register is free.
// ----------------------------------------------------------------------------
module gcl_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  logic [gcl_pkg::PIX_W-1:0]         i_pixel,
    input  logic [$clog2(MAX_WIDTH)-1:0]      i_col,
    input  gcl_pkg::t_cls                     i_cls,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [gcl_pkg::PIX_W-1:0]         o_pixel,
    output logic                              o_frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int PW = gcl_pkg::PIX_W;

    // line memories: low byte is the row above, high byte two rows above
    logic [2*PW-1:0]     r_in_mem  [MAX_WIDTH];
    logic [2*PW-1:0]     r_dil_mem [MAX_WIDTH];

    logic                w_adv;

    logic                r1_v;
    logic [PW-1:0]       r1_pix;
    logic [CW-1:0]       r1_col;
    gcl_pkg::t_cls       r1_cls;
    logic [2*PW-1:0]     r1_rd;

    logic                r2_v;
    logic [PW-1:0]       r2_cmax;
    logic [CW-1:0]       r2_col;
    gcl_pkg::t_cls       r2_cls;

    logic [2*PW-1:0]     r_hwin;
    logic                r3_v;
    logic [PW-1:0]       r3_dil;
    logic [CW-1:0]       r3_col;
    gcl_pkg::t_cls       r3_cls;

    logic                r4_v;
    logic [PW-1:0]       r4_dil;
    logic [CW-1:0]       r4_col;
    gcl_pkg::t_cls       r4_cls;
    logic [2*PW-1:0]     r4_rd;

    logic                r5_v;
    logic [PW-1:0]       r5_cmin;
    gcl_pkg::t_cls       r5_cls;

    logic [2*PW-1:0]     r_ewin;
    logic                r_out_valid;
    logic [PW-1:0]       r_out_pix;
    logic                r_out_last;

    assign w_adv = !r_out_valid || i_ready;
    assign o_pop = w_adv && i_q_valid;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            r4_v        <= 1'b0;
            r5_v        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r1_v        <= i_q_valid;
            r2_v        <= r1_v;
            r3_v        <= r2_v;
            r4_v        <= r3_v;
            r5_v        <= r4_v;
            r_out_valid <= r5_v && r5_cls.emit;
        end
    end

    // input line memory: read at pop, write back shifted one stage later
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_rd <= r_in_mem[i_col];
        end
        if (w_adv && r1_v) begin
            r_in_mem[r1_col] <= {r1_rd[PW-1:0], r1_pix};
        end
    end

    // dilated line memory
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_rd <= r_dil_mem[r3_col];
        end
        if (w_adv && r4_v) begin
            r_dil_mem[r4_col] <= {r4_rd[PW-1:0], r4_dil};
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_pix  <= i_pixel;
            r1_col  <= i_col;
            r1_cls  <= i_cls;

            r2_cmax <= gcl_pkg::max3(r1_rd[2*PW-1:PW], r1_rd[PW-1:0], r1_pix);
            r2_col  <= r1_col;
            r2_cls  <= r1_cls;

            r3_dil  <= gcl_pkg::max3(r_hwin[2*PW-1:PW], r_hwin[PW-1:0], r2_cmax);
            r3_col  <= r2_col;
            r3_cls  <= r2_cls;

            r4_dil  <= r3_dil;
            r4_col  <= r3_col;
            r4_cls  <= r3_cls;

            r5_cmin <= gcl_pkg::min3(r4_rd[2*PW-1:PW], r4_rd[PW-1:0], r4_dil);
            r5_cls  <= r4_cls;

            r_out_pix  <= r5_cls.interior ?
                          gcl_pkg::min3(r_ewin[2*PW-1:PW], r_ewin[PW-1:0], r5_cmin) : '0;
            r_out_last <= r5_cls.frame_end;
        end
        // horizontal windows shift on real pixels only
        if (w_adv && r2_v) begin
            r_hwin <= {r_hwin[PW-1:0], r2_cmax};
        end
        if (w_adv && r5_v) begin
            r_ewin <= {r_ewin[PW-1:0], r5_cmin};
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pixel     = r_out_pix;
    assign o_frame_end = r_out_last;

endmodule

>>> rtl/core/grayscale_closing_3x3_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grayscale_closing_3x3_core - 3x3 grey-level morphological closing
// Raster pixel stream in, closed pixel stream out (dilation then erosion).
// ----------------------------------------------------------------------------
// The core sustains one pixel per clock while the sink takes results: every
// stage of the back end moves in lockstep and each line memory takes one
// read and one write per pixel. A result for raster position n appears when
// input pixel n+2W+2 is taken; that pixel passes through the queue, then
// input-row read, column max, window max, dilated-row read and column min
// ahead of the output register, and is held back further only while the
// sink stalls; the last 2W+2 positions of a frame are not sent and
// m_axis_tlast marks the last result sent. Results
// within two pixels of any frame edge are zero. Frame size registers are
// clamped (width 3..MAX_WIDTH, height at least 3), and any write restarts
// the frame. Line memories need no clearing after reset.
module grayscale_closing_3x3_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gcl_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [gcl_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [7:0] pixel_in
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata,   // [7:0] pixel_out
    output logic                              m_axis_tlast    // frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int QW = gcl_pkg::PIX_W + CW + gcl_pkg::CLS_W;

    logic                     w_push;
    logic                     w_pop;
    logic [gcl_pkg::PIX_W-1:0] w_f_pix;
    logic [CW-1:0]            w_f_col;
    gcl_pkg::t_cls            w_f_cls;
    logic [QW-1:0]            w_q_din;
    logic [QW-1:0]            w_q_dout;
    gcl_pkg::t_q_sts          w_q_sts;
    logic [gcl_pkg::PIX_W-1:0] w_b_pix;
    logic [CW-1:0]            w_b_col;
    gcl_pkg::t_cls            w_b_cls;

    gcl_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_pixel     (s_axis_tdata),
        .i_q_full    (w_q_sts.full),
        .o_push      (w_push),
        .o_pixel     (w_f_pix),
        .o_col       (w_f_col),
        .o_cls       (w_f_cls)
    );

    assign w_q_din = {w_f_pix, w_f_col, w_f_cls};

    gcl_queue #(
        .DW    (QW),
        .DEPTH (4)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_din),
        .i_pop   (w_pop),
        .o_data  (w_q_dout),
        .o_sts   (w_q_sts)
    );

    assign {w_b_pix, w_b_col, w_b_cls} = w_q_dout;

    gcl_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (!w_q_sts.empty),
        .i_pixel     (w_b_pix),
        .i_col       (w_b_col),
        .i_cls       (w_b_cls),
        .o_pop       (w_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_pixel     (m_axis_tdata),
        .o_frame_end (m_axis_tlast)
    );

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && w_q_sts.empty)
        else $error("output or queue not cleared by reset");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_sts.full |-> !s_axis_tready)
        else $error("input request taken while queue full");

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_sts.empty)
        else $error("back end popped an empty queue");

endmodule

>>> dv/tb_grayscale_closing_3x3_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grayscale_closing_3x3_core - self-checking bench for the 3x3 closing core
// Streams random frames of many sizes through the core under random source
// gaps and sink stalls. A scoreboard recomputes each closed pixel from its
// own copy of the frame and checks data and tlast in order.
// ----------------------------------------------------------------------------
module tb_grayscale_closing_3x3_core;

    localparam int MAX_WIDTH        = 1024;
    localparam int SETTLE_CYCLES    = 16;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int RANDOM_PIXELS    = 1100;
    localparam int WIDE_PIXELS      = 200;

    typedef enum {PIX_UNIFORM, PIX_SPECKS, PIX_HOLES, PIX_BINARY} t_pixel_mix;

    typedef struct {
        logic [gcl_pkg::PIX_W-1:0] pixel;
        logic                      frame_end;
    } t_closed_px;

    class closing_scoreboard;
        logic [gcl_pkg::FW_W-1:0]  width_reg;
        logic [gcl_pkg::FH_W-1:0]  height_reg;
        int unsigned               col;
        int unsigned               row;
        logic [gcl_pkg::PIX_W-1:0] frame_px [int];
        t_closed_px                closed_q [$];
        int unsigned               mismatches;
        int unsigned               pixels_in;
        int unsigned               results_ok;
        int unsigned               interior_cnt;
        int unsigned               frame_ends;
        int unsigned               reg_writes;

        function new();
            width_reg    = gcl_pkg::FW_W'(gcl_pkg::FW_RESET);
            height_reg   = gcl_pkg::FH_W'(gcl_pkg::FH_RESET);
            col          = 0;
            row          = 0;
            mismatches   = 0;
            pixels_in    = 0;
            results_ok   = 0;
            interior_cnt = 0;
            frame_ends   = 0;
            reg_writes   = 0;
        endfunction

        function int unsigned eff_width();
            if (width_reg < gcl_pkg::MIN_DIM) return gcl_pkg::MIN_DIM;
            if (width_reg > MAX_WIDTH) return MAX_WIDTH;
            return 32'(width_reg);
        endfunction

        function int unsigned eff_height();
            if (height_reg < gcl_pkg::MIN_DIM) return gcl_pkg::MIN_DIM;
            return 32'(height_reg);
        endfunction

        // any write restarts the frame
        function void write_reg(input logic [gcl_pkg::CFG_ADDR_W-1:0] idx,
                                input logic [gcl_pkg::CFG_W-1:0] val);
            if (idx == gcl_pkg::CFG_FRAME_WIDTH) width_reg = val[gcl_pkg::FW_W-1:0];
            else height_reg = val[gcl_pkg::FH_W-1:0];
            col = 0;
            row = 0;
            reg_writes++;
        endfunction

        // min over 3x3 of the max over 3x3, all taps inside the current frame
        function logic [gcl_pkg::PIX_W-1:0] closed_value(input int r, input int c,
                                                          input int w);
            logic [gcl_pkg::PIX_W-1:0] lo;
            logic [gcl_pkg::PIX_W-1:0] hi;
            logic [gcl_pkg::PIX_W-1:0] px;
            lo = 8'hFF;
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    hi = 8'h00;
                    for (int er = -1; er <= 1; er++) begin
                        for (int ec = -1; ec <= 1; ec++) begin
                            px = frame_px[(r + dr + er) * w + c + dc + ec];
                            if (px > hi) hi = px;
                        end
                    end
                    if (hi < lo) lo = hi;
                end
            end
            return lo;
        endfunction

        function void note_pixel(input logic [gcl_pkg::PIX_W-1:0] pix);
            int unsigned w;
            int unsigned h;
            int unsigned m;
            int unsigned lead;
            int unsigned n;
            int unsigned r;
            int unsigned c;
            t_closed_px  want;
            w = eff_width();
            h = eff_height();
            if (col >= w || row >= h) begin
                col = 0;
                row = 0;
            end
            m = row * w + col;
            frame_px[m] = pix;
            lead = 2 * w + 2;
            pixels_in++;
            if (m >= lead) begin
                n = m - lead;
                r = n / w;
                c = n % w;
                want.pixel = 8'h00;
                if (r >= 2 && r + 3 <= h && c >= 2 && c + 3 <= w) begin
                    want.pixel = closed_value(r, c, w);
                    interior_cnt++;
                end
                want.frame_end = (n == h * w - lead - 1);
                if (want.frame_end) frame_ends++;
                closed_q.push_back(want);
            end
            col++;
            if (col >= w) begin
                col = 0;
                row++;
                if (row >= h) row = 0;
            end
        endfunction

        function void check_closed(input logic [gcl_pkg::PIX_W-1:0] pix, input logic last);
            t_closed_px want;
            if (closed_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result %02h last %0b with nothing pending",
                             $time, pix, last);
                return;
            end
            want = closed_q.pop_front();
            if (pix !== want.pixel || last !== want.frame_end) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: expected %02h last %0b, got %02h last %0b",
                             $time, want.pixel, want.frame_end, pix, last);
            end else begin
                results_ok++;
            end
        endfunction
    endclass

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_we      = 1'b0;
    logic [gcl_pkg::CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [gcl_pkg::CFG_W-1:0]      i_cfg_wdata   = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [7:0]                     s_axis_tdata  = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [7:0]                     m_axis_tdata;
    logic                           m_axis_tlast;

    closing_scoreboard sb;

    int burst_left  = 0;
    int hold_asked  = 0;
    int hold_served = 0;
    int hold_left   = 0;
    int mode_left   = 0;
    int stall_pct   = 0;

    logic [7:0] directed_px [25] = '{
        8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01,
        8'h80, 8'hFE, 8'h7F, 8'h10, 8'h20,
        8'h40, 8'h00, 8'h08, 8'h00, 8'h04,
        8'hC0, 8'h02, 8'h00, 8'hE0, 8'h30,
        8'hFF, 8'h00, 8'h90, 8'h11, 8'h00
    };

    grayscale_closing_3x3_core #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // everything is sampled with the values that held just before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.write_reg(i_cfg_addr, i_cfg_wdata);
            if (s_axis_tvalid && s_axis_tready) sb.note_pixel(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) sb.check_closed(m_axis_tdata, m_axis_tlast);
        end
    end

    // sink: random stall modes, plus a long hold whenever the stimulus asks
    always @(posedge i_clk) begin
        if (hold_served != hold_asked) begin
            hold_served   <= hold_asked;
            hold_left     <= LONG_HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode_left <= $urandom_range(40, 400);
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct <= 0;
                    2:       stall_pct <= 25;
                    3:       stall_pct <= 50;
                    default: stall_pct <= 80;
                endcase
            end else begin
                mode_left <= mode_left - 1;
            end
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic logic [7:0] make_pixel(input t_pixel_mix mix);
        logic [7:0] px;
        case (mix)
            PIX_SPECKS: px = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(128, 255))
                                                         : 8'($urandom_range(0, 15));
            PIX_HOLES:  px = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 40))
                                                         : 8'($urandom_range(200, 255));
            PIX_BINARY: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:    px = 8'($urandom_range(0, 255));
        endcase
        return px;
    endfunction

    // source works in bursts; valid stays up across back-to-back requests
    task automatic offer_pixel(input logic [7:0] pix);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic park_sender();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
    endtask

    task automatic wait_for_results();
        while (sb.closed_q.size() != 0) @(posedge i_clk);
    endtask

    // pixels near the frame start give no result, so give the pipe time to empty
    task automatic settle();
        park_sender();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [gcl_pkg::CFG_ADDR_W-1:0] idx,
                                  input logic [gcl_pkg::CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input t_pixel_mix mix, input int count, input bit hold,
                             input int pause_at);
        if (hold) hold_asked <= hold_asked + 1;
        for (int i = 0; i < count; i++) begin
            if (i == pause_at) begin
                park_sender();
                wait_for_results();
            end
            offer_pixel(make_pixel(mix));
        end
        settle();
    endtask

    initial begin
        int                        w;
        int                        h;
        int                        count;
        int                        random_px;
        logic [gcl_pkg::CFG_W-1:0] wval;
        logic [gcl_pkg::CFG_W-1:0] hval;
        sb = new();
        random_px = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 5x5 frame: twelve silent requests, border zeros, one interior pixel, tlast
        write_register(gcl_pkg::CFG_FRAME_WIDTH, 12'd5);
        write_register(gcl_pkg::CFG_FRAME_HEIGHT, 12'd5);
        foreach (directed_px[i]) offer_pixel(directed_px[i]);
        settle();

        // both sizes below the minimum clamp to 3x3
        write_register(gcl_pkg::CFG_FRAME_WIDTH, 12'd0);
        write_register(gcl_pkg::CFG_FRAME_HEIGHT, 12'd0);
        run_phase(PIX_BINARY, 27, 1'b0, 13);
        // width bit above the register is dropped; very tall frame left unfinished
        write_register(gcl_pkg::CFG_FRAME_WIDTH, 12'h807);
        write_register(gcl_pkg::CFG_FRAME_HEIGHT, 12'hFFF);
        run_phase(PIX_UNIFORM, 120, 1'b1, -1);

        while (random_px < RANDOM_PIXELS) begin
            case ($urandom_range(0, 9))
                0:       wval = 12'($urandom_range(0, 4));
                1:       wval = 12'h800 | 12'($urandom_range(5, 12));
                default: wval = 12'($urandom_range(5, 12));
            endcase
            case ($urandom_range(0, 9))
                0:       hval = 12'($urandom_range(0, 4));
                1:       hval = 12'($urandom_range(4000, 4095));
                default: hval = 12'($urandom_range(5, 9));
            endcase
            case ($urandom_range(0, 7))
                0: ;    // carry on with the current frame
                1: write_register(gcl_pkg::CFG_FRAME_WIDTH, wval);
                2: write_register(gcl_pkg::CFG_FRAME_HEIGHT, hval);
                3: begin
                    write_register(gcl_pkg::CFG_FRAME_HEIGHT, hval);
                    write_register(gcl_pkg::CFG_FRAME_WIDTH, wval);
                end
                default: begin
                    write_register(gcl_pkg::CFG_FRAME_WIDTH, wval);
                    write_register(gcl_pkg::CFG_FRAME_HEIGHT, hval);
                end
            endcase
            w = sb.eff_width();
            h = sb.eff_height();
            if (h > 16)
                count = $urandom_range(3 * w, 12 * w);
            else
                count = $urandom_range(1, 3) * w * h +
                        (($urandom_range(0, 2) == 0) ? $urandom_range(1, w * h - 1) : 0);
            run_phase(t_pixel_mix'($urandom_range(0, 3)), count,
                      (count >= 60 && $urandom_range(0, 2) == 0),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, count - 1) : -1);
            random_px += count;
        end

        // oversized width clamps to the widest line; start of frame stays silent
        write_register(gcl_pkg::CFG_FRAME_WIDTH, 12'h7FF);
        write_register(gcl_pkg::CFG_FRAME_HEIGHT, 12'hFFF);
        run_phase(PIX_UNIFORM, WIDE_PIXELS, 1'b0, WIDE_PIXELS / 2);

        $display("run covered %0d pixels in, %0d results matched (%0d interior, %0d frame ends)",
                 sb.pixels_in, sb.results_ok, sb.interior_cnt, sb.frame_ends);
        $display("%0d register writes over widths 3..%0d and heights 3..4095, %0d mismatches",
                 sb.reg_writes, MAX_WIDTH, sb.mismatches);
        if (sb.mismatches == 0 && sb.closed_q.size() == 0) begin
            $display("tb_grayscale_closing_3x3_core: clean");
        end else begin
            $display("tb_grayscale_closing_3x3_core: errors");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d results pending", sb.closed_q.size());
        $display("tb_grayscale_closing_3x3_core: errors");
        $finish;
    end

endmodule
